// File: src/aco_pkg.sv
// Shared types and constants for the Aho-Corasick occurrence counter.
`timescale 1ns / 1ps
package aco_pkg;

  localparam int MAX_NODES_DEF    = 4096;
  localparam int ALPHABET_DEF     = 26;
  localparam int MAX_PATTERNS_DEF = 1024;

  localparam int KIND_W = 3;
  localparam int SYM_W  = 5;
  localparam int IDX_W  = 10;
  localparam int WT_W   = 11;
  localparam int CNT_W  = 40;

  localparam logic [WT_W-1:0]  WEIGHT_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [KIND_W-1:0] {
    K_PSYM  = 3'd0,
    K_PEND  = 3'd1,
    K_BUILD = 3'd2,
    K_ACT   = 3'd3,
    K_TSYM  = 3'd4,
    K_TEND  = 3'd5,
    K_WCLR  = 3'd6
  } aco_kind_t;

  typedef struct packed {
    logic goto_we;
    logic fail_we;
    logic wt_we;
    logic q_we;
    logic pe_we;
  } aco_we_t;

endpackage

// File: src/aco_in_if.sv
// Input channel interface: command kind, symbol and pattern index.
`timescale 1ns / 1ps
interface aco_in_if
  import aco_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [IDX_W-1:0]  pattern_index;

  modport source (output valid, kind, symbol, pattern_index, input ready);
  modport sink   (input valid, kind, symbol, pattern_index, output ready);
endinterface

// File: src/aco_out_if.sv
// Result channel interface: count, assigned index and full flag.
`timescale 1ns / 1ps
interface aco_out_if
  import aco_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] assigned_index;
  logic             full_res;

  modport source (output valid, count, assigned_index, full_res, input ready);
  modport sink   (input valid, count, assigned_index, full_res, output ready);
endinterface

// File: src/aho_corasick_occurrence_counter.sv
// Top level of the Aho-Corasick occurrence counter.
//
//   channel | dir | transaction           | payload
//   in_if   | in  | valid & ready         | kind, symbol, pattern_index
//   out_if  | out | valid & ready         | count, assigned_index, full_res
//
// A text symbol walks the failure chain of its node, one weight and link read a cycle;
// a pattern or text end waits until the output register can take its result.
// Build walks the trie breadth first, with at most one goto access a cycle.
// Clear weights writes one weight entry a cycle.
// After reset a clearing pass over all MAX_NODES*ALPHABET goto entries (106496 by default)
// runs with in_if.ready low. A stalled result holds out_if; items that give no
// result are still taken meanwhile.
`timescale 1ns / 1ps
module aho_corasick_occurrence_counter
  import aco_pkg::*;
#(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int ALPHABET     = ALPHABET_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  aco_in_if.sink    in_if,
  aco_out_if.source out_if
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int GW = $clog2(MAX_NODES * ALPHABET);
  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  aco_we_t         we;
  logic [GW-1:0]   goto_raddr;
  logic [GW-1:0]   goto_waddr;
  logic [NW-1:0]   goto_wdata;
  logic [NW-1:0]   goto_rdata;
  logic [NW-1:0]   fail_raddr;
  logic [NW-1:0]   fail_waddr;
  logic [NW-1:0]   fail_wdata;
  logic [NW-1:0]   fail_rdata;
  logic [NW-1:0]   wt_raddr;
  logic [NW-1:0]   wt_waddr;
  logic [WT_W-1:0] wt_wdata;
  logic [WT_W-1:0] wt_rdata;
  logic [NW-1:0]   q_raddr;
  logic [NW-1:0]   q_waddr;
  logic [NW-1:0]   q_wdata;
  logic [NW-1:0]   q_rdata;
  logic [PW-1:0]   pe_raddr;
  logic [PW-1:0]   pe_waddr;
  logic [NW-1:0]   pe_wdata;
  logic [NW-1:0]   pe_rdata;

  aco_ctrl #(
    .MAX_NODES    (MAX_NODES),
    .ALPHABET     (ALPHABET),
    .MAX_PATTERNS (MAX_PATTERNS),
    .NW           (NW),
    .GW           (GW),
    .PW           (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .we         (we),
    .goto_raddr (goto_raddr),
    .goto_waddr (goto_waddr),
    .goto_wdata (goto_wdata),
    .goto_rdata (goto_rdata),
    .fail_raddr (fail_raddr),
    .fail_waddr (fail_waddr),
    .fail_wdata (fail_wdata),
    .fail_rdata (fail_rdata),
    .wt_raddr   (wt_raddr),
    .wt_waddr   (wt_waddr),
    .wt_wdata   (wt_wdata),
    .wt_rdata   (wt_rdata),
    .q_raddr    (q_raddr),
    .q_waddr    (q_waddr),
    .q_wdata    (q_wdata),
    .q_rdata    (q_rdata),
    .pe_raddr   (pe_raddr),
    .pe_waddr   (pe_waddr),
    .pe_wdata   (pe_wdata),
    .pe_rdata   (pe_rdata)
  );

  aco_tables #(
    .MAX_NODES    (MAX_NODES),
    .ALPHABET     (ALPHABET),
    .MAX_PATTERNS (MAX_PATTERNS),
    .NW           (NW),
    .GW           (GW),
    .PW           (PW)
  ) u_tables (
    .clk        (clk),
    .we         (we),
    .goto_raddr (goto_raddr),
    .goto_waddr (goto_waddr),
    .goto_wdata (goto_wdata),
    .goto_rdata (goto_rdata),
    .fail_raddr (fail_raddr),
    .fail_waddr (fail_waddr),
    .fail_wdata (fail_wdata),
    .fail_rdata (fail_rdata),
    .wt_raddr   (wt_raddr),
    .wt_waddr   (wt_waddr),
    .wt_wdata   (wt_wdata),
    .wt_rdata   (wt_rdata),
    .q_raddr    (q_raddr),
    .q_waddr    (q_waddr),
    .q_wdata    (q_wdata),
    .q_rdata    (q_rdata),
    .pe_raddr   (pe_raddr),
    .pe_waddr   (pe_waddr),
    .pe_wdata   (pe_wdata),
    .pe_rdata   (pe_rdata)
  );

endmodule

// File: src/aco_tables.sv
// Synchronous memories: goto table, failure links, weights, BFS queue, pattern ends.
`timescale 1ns / 1ps
module aco_tables
  import aco_pkg::*;
#(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int ALPHABET     = ALPHABET_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
  parameter int NW           = $clog2(MAX_NODES),
  parameter int GW           = $clog2(MAX_NODES * ALPHABET),
  parameter int PW           = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
  input  logic            clk,
  input  aco_we_t         we,
  input  logic [GW-1:0]   goto_raddr,
  input  logic [GW-1:0]   goto_waddr,
  input  logic [NW-1:0]   goto_wdata,
  output logic [NW-1:0]   goto_rdata,
  input  logic [NW-1:0]   fail_raddr,
  input  logic [NW-1:0]   fail_waddr,
  input  logic [NW-1:0]   fail_wdata,
  output logic [NW-1:0]   fail_rdata,
  input  logic [NW-1:0]   wt_raddr,
  input  logic [NW-1:0]   wt_waddr,
  input  logic [WT_W-1:0] wt_wdata,
  output logic [WT_W-1:0] wt_rdata,
  input  logic [NW-1:0]   q_raddr,
  input  logic [NW-1:0]   q_waddr,
  input  logic [NW-1:0]   q_wdata,
  output logic [NW-1:0]   q_rdata,
  input  logic [PW-1:0]   pe_raddr,
  input  logic [PW-1:0]   pe_waddr,
  input  logic [NW-1:0]   pe_wdata,
  output logic [NW-1:0]   pe_rdata
);

  localparam int GDEPTH = MAX_NODES * ALPHABET;
  localparam int PDEPTH = (MAX_PATTERNS > 1) ? MAX_PATTERNS : 2;

  logic [NW-1:0]   goto_mem [GDEPTH];
  logic [NW-1:0]   fail_mem [MAX_NODES];
  logic [WT_W-1:0] wt_mem   [MAX_NODES];
  logic [NW-1:0]   q_mem    [MAX_NODES];
  logic [NW-1:0]   pe_mem   [PDEPTH];

  always_ff @(posedge clk) begin
    if (we.goto_we) begin
      goto_mem[goto_waddr] <= goto_wdata;
    end
    goto_rdata <= goto_mem[goto_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.pe_we) begin
      pe_mem[pe_waddr] <= pe_wdata;
    end
    pe_rdata <= pe_mem[pe_raddr];
  end

endmodule

// File: src/aco_ctrl.sv
// Sequencer: trie insert, link build, activation, scan, weight clear and result register.
`timescale 1ns / 1ps
module aco_ctrl
  import aco_pkg::*;
#(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int ALPHABET     = ALPHABET_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
  parameter int NW           = $clog2(MAX_NODES),
  parameter int GW           = $clog2(MAX_NODES * ALPHABET),
  parameter int PW           = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  aco_in_if.sink          in_if,
  aco_out_if.source       out_if,
  output aco_we_t         we,
  output logic [GW-1:0]   goto_raddr,
  output logic [GW-1:0]   goto_waddr,
  output logic [NW-1:0]   goto_wdata,
  input  logic [NW-1:0]   goto_rdata,
  output logic [NW-1:0]   fail_raddr,
  output logic [NW-1:0]   fail_waddr,
  output logic [NW-1:0]   fail_wdata,
  input  logic [NW-1:0]   fail_rdata,
  output logic [NW-1:0]   wt_raddr,
  output logic [NW-1:0]   wt_waddr,
  output logic [WT_W-1:0] wt_wdata,
  input  logic [WT_W-1:0] wt_rdata,
  output logic [NW-1:0]   q_raddr,
  output logic [NW-1:0]   q_waddr,
  output logic [NW-1:0]   q_wdata,
  input  logic [NW-1:0]   q_rdata,
  output logic [PW-1:0]   pe_raddr,
  output logic [PW-1:0]   pe_waddr,
  output logic [NW-1:0]   pe_wdata,
  input  logic [NW-1:0]   pe_rdata
);

  localparam int CW     = $clog2(ALPHABET);
  localparam int GDEPTH = MAX_NODES * ALPHABET;

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_IDLE = 18'h00002,
    S_INS  = 18'h00004,
    S_SCAN = 18'h00008,
    S_SACC = 18'h00010,
    S_ACT0 = 18'h00020,
    S_ACT1 = 18'h00040,
    S_WCLR = 18'h00080,
    S_EMIT = 18'h00100,
    S_RT0  = 18'h00200,
    S_RT1  = 18'h00400,
    S_QRD  = 18'h00800,
    S_QWT  = 18'h01000,
    S_FWT  = 18'h02000,
    S_BAL  = 18'h04000,
    S_BCH  = 18'h08000,
    S_BWB  = 18'h10000,
    S_SPR  = 18'h20000
  } aco_state_t;

  aco_state_t       state_r;
  logic [GW-1:0]    clr_r;
  logic [NW-1:0]    insert_node_r;
  logic [NW-1:0]    scan_node_r;
  logic [NW:0]      nodes_used_r;
  logic [PW:0]      patterns_used_r;
  logic [CNT_W-1:0] count_r;
  logic             built_r;
  logic             ovf_r;
  logic [NW:0]      head_r;
  logic [NW:0]      tail_r;
  logic [NW-1:0]    u_r;
  logic [NW-1:0]    fu_r;
  logic [CW-1:0]    col_r;
  logic [NW-1:0]    alt_r;
  logic [GW-1:0]    ga_r;
  logic [NW-1:0]    n_r;
  logic [CNT_W-1:0] res_count_r;
  logic [IDX_W-1:0] res_idx_r;
  logic             res_full_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_full_r;

  logic             accept;
  aco_kind_t        kind;
  logic [CW-1:0]    sym;
  logic             sym_ok;
  logic             pend_ok;
  logic             act_ok;
  logic             node_room;
  logic             q_room;
  logic [CNT_W:0]   sum;

  function automatic logic [GW-1:0] slot(input logic [NW-1:0] n, input logic [CW-1:0] c);
    return GW'(n) * GW'(ALPHABET) + GW'(c);
  endfunction

  assign kind      = aco_kind_t'(in_if.kind);
  assign sym       = CW'(in_if.symbol);
  assign sym_ok    = 32'(in_if.symbol) < ALPHABET;
  assign accept    = in_if.valid && in_if.ready;
  assign pend_ok   = !built_r && !ovf_r && (32'(patterns_used_r) < MAX_PATTERNS);
  assign act_ok    = (32'(in_if.pattern_index) < 32'(patterns_used_r)) &&
                     (32'(in_if.pattern_index) < MAX_PATTERNS);
  assign node_room = 32'(nodes_used_r) < MAX_NODES;
  assign q_room    = 32'(tail_r) < MAX_NODES;
  assign sum       = {1'b0, count_r} + (CNT_W + 1)'(wt_rdata);

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.count          = out_count_r;
  assign out_if.assigned_index = out_idx_r;
  assign out_if.full_res       = out_full_r;

  always_comb begin
    we         = '0;
    goto_raddr = '0;
    goto_waddr = '0;
    goto_wdata = '0;
    fail_raddr = '0;
    fail_waddr = '0;
    fail_wdata = '0;
    wt_raddr   = '0;
    wt_waddr   = '0;
    wt_wdata   = '0;
    q_raddr    = '0;
    q_waddr    = '0;
    q_wdata    = '0;
    pe_raddr   = PW'(in_if.pattern_index);
    pe_waddr   = patterns_used_r[PW-1:0];
    pe_wdata   = insert_node_r;
    unique case (state_r)
      S_CLR: begin
        we.goto_we = 1'b1;
        goto_waddr = clr_r;
        if (32'(clr_r) < MAX_NODES) begin
          we.fail_we = 1'b1;
          we.wt_we   = 1'b1;
          fail_waddr = clr_r[NW-1:0];
          wt_waddr   = clr_r[NW-1:0];
        end
      end
      S_IDLE: begin
        goto_raddr = (kind == K_TSYM) ? slot(scan_node_r, sym) : slot(insert_node_r, sym);
        we.pe_we   = accept && (kind == K_PEND) && pend_ok;
      end
      S_INS: begin
        if (goto_rdata == '0 && node_room) begin
          we.goto_we = 1'b1;
          goto_waddr = ga_r;
          goto_wdata = nodes_used_r[NW-1:0];
        end
      end
      S_SCAN: begin
        wt_raddr   = goto_rdata;
        fail_raddr = goto_rdata;
      end
      S_SACC: begin
        wt_raddr   = fail_rdata;
        fail_raddr = fail_rdata;
      end
      S_ACT0: wt_raddr = pe_rdata;
      S_ACT1: begin
        if (wt_rdata != WEIGHT_MAX) begin
          we.wt_we = 1'b1;
          wt_waddr = n_r;
          wt_wdata = wt_rdata + WT_W'(1);
        end
      end
      S_WCLR: begin
        we.wt_we = 1'b1;
        wt_waddr = clr_r[NW-1:0];
      end
      S_RT0: goto_raddr = GW'(col_r);
      S_RT1: begin
        if (goto_rdata != '0 && q_room) begin
          we.q_we = 1'b1;
          q_waddr = tail_r[NW-1:0];
          q_wdata = goto_rdata;
        end
      end
      S_QRD: q_raddr = head_r[NW-1:0];
      S_QWT: fail_raddr = q_rdata;
      S_BAL: goto_raddr = slot(fu_r, col_r);
      S_BCH: goto_raddr = slot(u_r, col_r);
      S_BWB: begin
        if (goto_rdata != '0) begin
          we.fail_we = 1'b1;
          fail_waddr = goto_rdata;
          fail_wdata = alt_r;
          if (q_room) begin
            we.q_we = 1'b1;
            q_waddr = tail_r[NW-1:0];
            q_wdata = goto_rdata;
          end
        end else begin
          we.goto_we = 1'b1;
          goto_waddr = ga_r;
          goto_wdata = alt_r;
        end
      end
      S_FWT, S_EMIT, S_SPR: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLR;
      clr_r           <= '0;
      insert_node_r   <= '0;
      scan_node_r     <= '0;
      nodes_used_r    <= (NW + 1)'(1);
      patterns_used_r <= '0;
      count_r         <= '0;
      built_r         <= 1'b0;
      ovf_r           <= 1'b0;
      head_r          <= '0;
      tail_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + GW'(1);
          if (32'(clr_r) == GDEPTH - 1) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            case (kind)
              K_PSYM: begin
                if (!built_r && sym_ok && !ovf_r) begin
                  ga_r    <= slot(insert_node_r, sym);
                  state_r <= S_INS;
                end
              end
              K_PEND: begin
                res_count_r <= '0;
                if (pend_ok) begin
                  res_idx_r       <= IDX_W'(patterns_used_r);
                  res_full_r      <= 1'b0;
                  patterns_used_r <= patterns_used_r + (PW + 1)'(1);
                end else begin
                  res_idx_r  <= '0;
                  res_full_r <= 1'b1;
                end
                insert_node_r <= '0;
                ovf_r         <= 1'b0;
                state_r       <= S_EMIT;
              end
              K_BUILD: begin
                if (!built_r) begin
                  col_r   <= '0;
                  head_r  <= '0;
                  tail_r  <= '0;
                  state_r <= S_RT0;
                end
              end
              K_ACT: begin
                if (act_ok) begin
                  state_r <= S_ACT0;
                end
              end
              K_TSYM: begin
                if (sym_ok) begin
                  state_r <= S_SCAN;
                end
              end
              K_TEND: begin
                res_count_r <= count_r;
                res_idx_r   <= '0;
                res_full_r  <= 1'b0;
                count_r     <= '0;
                scan_node_r <= '0;
                state_r     <= S_EMIT;
              end
              K_WCLR: begin
                clr_r   <= '0;
                state_r <= S_WCLR;
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          if (goto_rdata != '0) begin
            insert_node_r <= goto_rdata;
          end else if (node_room) begin
            insert_node_r <= nodes_used_r[NW-1:0];
            nodes_used_r  <= nodes_used_r + (NW + 1)'(1);
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          scan_node_r <= goto_rdata;
          state_r     <= (goto_rdata != '0) ? S_SACC : S_IDLE;
        end
        S_SACC: begin
          count_r <= sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
          if (fail_rdata == '0) begin
            state_r <= S_IDLE;
          end
        end
        S_ACT0: begin
          n_r     <= pe_rdata;
          state_r <= S_ACT1;
        end
        S_ACT1: state_r <= S_IDLE;
        S_WCLR: begin
          clr_r <= clr_r + GW'(1);
          if (32'(clr_r) == MAX_NODES - 1) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_count_r <= res_count_r;
            out_idx_r   <= res_idx_r;
            out_full_r  <= res_full_r;
            state_r     <= S_IDLE;
          end
        end
        S_RT0: state_r <= S_RT1;
        S_RT1: begin
          if (goto_rdata != '0 && q_room) begin
            tail_r <= tail_r + (NW + 1)'(1);
          end
          if (32'(col_r) == ALPHABET - 1) begin
            state_r <= S_QRD;
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_RT0;
          end
        end
        S_QRD: begin
          if (head_r == tail_r) begin
            built_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            head_r  <= head_r + (NW + 1)'(1);
            state_r <= S_QWT;
          end
        end
        S_QWT: begin
          u_r     <= q_rdata;
          state_r <= S_FWT;
        end
        S_FWT: begin
          fu_r    <= fail_rdata;
          col_r   <= '0;
          state_r <= S_BAL;
        end
        S_BAL: state_r <= S_BCH;
        S_BCH: begin
          alt_r   <= goto_rdata;
          ga_r    <= slot(u_r, col_r);
          state_r <= S_BWB;
        end
        S_BWB: begin
          if (goto_rdata != '0 && q_room) begin
            tail_r <= tail_r + (NW + 1)'(1);
          end
          if (32'(col_r) == ALPHABET - 1) begin
            state_r <= S_QRD;
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_BAL;
          end
        end
        S_SPR: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r != '0 && 32'(nodes_used_r) <= MAX_NODES)
    else $error("node count out of range");

  a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(built_r))
    else $error("links built flag dropped");

  a_result_emit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind == K_PEND || kind == K_TEND) |=> state_r == S_EMIT)
    else $error("result transaction not staged");
`endif

endmodule

// File: tb/tb_aho_corasick_occurrence_counter.sv
// Self-checking testbench for the Aho-Corasick occurrence counter.
`timescale 1ns / 1ps
module tb_aho_corasick_occurrence_counter;
  import aco_pkg::*;

  localparam int MAXN = MAX_NODES_DEF;
  localparam int ALPH = ALPHABET_DEF;
  localparam int MAXP = MAX_PATTERNS_DEF;
  localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx;
    logic             full;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  aco_in_if  in_if();
  aco_out_if out_if();

  aho_corasick_occurrence_counter i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if)
  );

  always #5 clk = ~clk;

  int unsigned goto_t [MAXN*ALPH];
  int unsigned fail_t [MAXN];
  int unsigned weight_t [MAXN];
  int unsigned queue_t [MAXN];
  int unsigned end_node [MAXP];
  int unsigned nodes_used = 1;
  int unsigned pats_used = 0;
  int unsigned ins_node = 0;
  int unsigned scan_node = 0;
  logic [CNT_W-1:0] occ_count = '0;
  bit built = 0;
  bit ovf = 0;

  result_t expected_results[$];
  int errors = 0;
  bit calm = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void build_links();
    int unsigned head, tail, u, v, alt;
    head = 0;
    tail = 0;
    for (int c = 0; c < ALPH; c++) begin
      v = goto_t[c];
      if (v != 0 && tail < MAXN) begin
        fail_t[v] = 0;
        queue_t[tail++] = v;
      end
    end
    while (head < tail) begin
      u = queue_t[head++];
      for (int c = 0; c < ALPH; c++) begin
        alt = goto_t[fail_t[u]*ALPH + c];
        v = goto_t[u*ALPH + c];
        if (v != 0) begin
          fail_t[v] = alt;
          if (tail < MAXN) queue_t[tail++] = v;
        end else begin
          goto_t[u*ALPH + c] = alt;
        end
      end
    end
    built = 1;
  endfunction

  function automatic void predict(logic [KIND_W-1:0] kind, int unsigned sym,
                                  int unsigned idx);
    result_t r;
    int unsigned slot, x, steps;
    logic [CNT_W:0] sum;
    case (kind)
      K_PSYM: begin
        if (!built && sym < ALPH && !ovf) begin
          slot = ins_node*ALPH + sym;
          if (goto_t[slot] != 0) ins_node = goto_t[slot];
          else if (nodes_used < MAXN) begin
            goto_t[slot] = nodes_used;
            ins_node = nodes_used;
            nodes_used++;
          end else ovf = 1;
        end
      end
      K_PEND: begin
        r.count = '0;
        if (built || ovf || pats_used >= MAXP) begin
          r.idx = '0;
          r.full = 1'b1;
        end else begin
          end_node[pats_used] = ins_node;
          r.idx = pats_used[IDX_W-1:0];
          r.full = 1'b0;
          pats_used++;
        end
        ins_node = 0;
        ovf = 0;
        expected_results.insert(expected_results.size(), r);
      end
      K_BUILD: if (!built) build_links();
      K_ACT: begin
        if (idx < pats_used && weight_t[end_node[idx]] < WEIGHT_MAX)
          weight_t[end_node[idx]]++;
      end
      K_TSYM: begin
        if (sym < ALPH) begin
          scan_node = goto_t[scan_node*ALPH + sym];
          x = scan_node;
          steps = 0;
          while (x != 0 && steps < MAXN) begin
            sum = {1'b0, occ_count} + weight_t[x];
            occ_count = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
            x = fail_t[x];
            steps++;
          end
        end
      end
      K_TEND: begin
        r.count = occ_count;
        r.idx = '0;
        r.full = 1'b0;
        expected_results.insert(expected_results.size(), r);
        occ_count = '0;
        scan_node = 0;
      end
      K_WCLR: for (int n = 0; n < MAXN; n++) weight_t[n] = 0;
      default: ;
    endcase
  endfunction

  task automatic send(logic [KIND_W-1:0] kind, int unsigned sym = 0,
                      int unsigned idx = 0);
    while (!calm && $urandom_range(99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.symbol <= sym[SYM_W-1:0];
    in_if.pattern_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (!in_if.ready);
    predict(kind, sym, idx);
  endtask

  task automatic send_word(int unsigned len, int unsigned top, logic [KIND_W-1:0] kind);
    for (int i = 0; i < len; i++) send(kind, $urandom_range(top));
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_if.ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result count", out_if.count, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_if.count !== want.count) report("count", out_if.count, want.count);
        if (out_if.assigned_index !== want.idx)
          report("assigned_index", out_if.assigned_index, want.idx);
        if (out_if.full_res !== want.full) report("full_res", out_if.full_res, want.full);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[aho_corasick_occurrence_counter] ERROR");
      $finish;
    end
  end

  task automatic test_before_build();
    send(K_PEND);
    send(K_PSYM, 0); send(K_PSYM, 1); send(K_PEND);
    send(K_PSYM, 1); send(K_PEND);
    send(K_PSYM, 31); send(K_PSYM, 26); send(K_PEND);
    send(K_ACT, 0, 1023); send(K_ACT, 1); send(K_ACT, 2); send(K_ACT, 3);
    send(K_ACT, 0, 5);
    send(K_UNUSED, 31, 1023);
    send(K_TSYM, 0); send(K_TSYM, 1); send(K_TSYM, 16); send(K_TSYM, 0);
    send(K_TSYM, 1); send(K_TEND);
    send(K_WCLR);
    send(K_TSYM, 1); send(K_TEND);
  endtask

  task automatic test_load_short();
    hold_req = 1;
    for (int p = 0; p < 150; p++) begin
      send_word($urandom_range(6, 1), 3, K_PSYM);
      if ($urandom_range(9) == 0) send(K_PSYM, $urandom_range(31, 26));
      send(K_PEND);
    end
  endtask

  task automatic test_build();
    send(K_BUILD);
    send(K_BUILD);
    send(K_PSYM, 0); send(K_PEND);
  endtask

  task automatic test_random_text();
    int unsigned pick;
    for (int i = 0; i < 1200; i++) begin
      if (i == 400) calm = 1;
      if (i == 700) calm = 0;
      pick = $urandom_range(99);
      if (pick < 65) send(K_TSYM, ($urandom_range(9) == 0) ? $urandom_range(31) :
                                  $urandom_range(3));
      else if (pick < 70) send(K_TEND);
      else if (pick < 86) send(K_ACT, 0, ($urandom_range(4) == 0) ? $urandom_range(1023) :
                                          $urandom_range(160));
      else if (pick < 87) send(K_WCLR);
      else if (pick < 90) send(K_PSYM, $urandom_range(31));
      else if (pick < 92) send(K_PEND);
      else if (pick < 94) send(K_BUILD);
      else if (pick < 96) send(K_UNUSED, $urandom_range(31), $urandom_range(1023));
      else send(K_TEND);
    end
    send(K_TEND);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = K_PSYM;
    in_if.symbol = '0;
    in_if.pattern_index = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_before_build();
    test_load_short();
    test_build();
    test_random_text();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[aho_corasick_occurrence_counter] OK");
    else $display("[aho_corasick_occurrence_counter] ERROR");
    $finish;
  end

endmodule

// File: aho_corasick_occurrence_counter.f
src/aco_pkg.sv
src/aco_in_if.sv
src/aco_out_if.sv
src/aco_tables.sv
src/aco_ctrl.sv
src/aho_corasick_occurrence_counter.sv
tb/tb_aho_corasick_occurrence_counter.sv
